>>> hdl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // Bytes of block header in front of the user area
  localparam int unsigned HDR_BYTES = 2;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_IGNORED = 2'd1,
    STS_TOO_BIG = 2'd2,
    STS_NO_MEM  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_POP,
    S_SPLIT,
    S_REC,
    S_MCHK,
    S_SCAN,
    S_SHIFT,
    S_PUSH,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 4
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     we_i,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  logic [WIDTH-1:0]         wdata_i,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic       [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/buddy_block_allocator.sv
`default_nettype none

// Buddy allocator over an arena of TOP_BLOCKS blocks of 2^ORD_MAX bytes. Every
// order keeps a LIFO free stack; all stacks share one single-port-read RAM, and
// the order of each granted block sits in a second RAM. One request is worked at
// a time and answered with exactly one result; a new request is taken as soon as
// the previous one has reached the output register. An allocate searches the
// orders upward for a free block and pushes each half split off it. A free
// scans the stack at each order for the buddy, moves the entries above it down,
// merges and pushes the block at the order where merging stops, all bound by
// the one read per cycle of the stack RAM. A reinitialise refills the top-order
// stack with top_blocks_in_use blocks; after reset the same fill pass runs over
// min(TOP_BLOCKS, 16) blocks with no request taken.
module buddy_block_allocator #(
  parameter int unsigned ORD_MIN    = 4,
  parameter int unsigned ORD_MAX    = 12,
  parameter int unsigned TOP_BLOCKS = 16
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_we_i,
  input  wire  logic [4:0]  cfg_wdata_i,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic [1:0]  req_type_i,
  input  wire  logic [15:0] request_size_i,
  input  wire  logic [15:0] address_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [1:0]        status_o,
  output logic [15:0]       granted_address_o,
  output logic [3:0]        granted_order_o
);

  localparam int unsigned SPAN   = ORD_MAX - ORD_MIN;
  localparam int unsigned UNITS  = TOP_BLOCKS << SPAN;
  localparam int unsigned BW     = $clog2(UNITS);
  localparam int unsigned AW     = $clog2(2 * UNITS);
  localparam int unsigned CW     = $clog2(UNITS + 1);
  localparam int unsigned LI     = $clog2(SPAN + 1);
  localparam int unsigned OW     = $clog2(ORD_MAX + 1);
  localparam int unsigned TW     = $clog2(TOP_BLOCKS + 1);
  localparam int unsigned TBU_RST = (TOP_BLOCKS < 16) ? TOP_BLOCKS : 16;
  localparam logic [AW:0] TWO_U  = (AW + 1)'(2 * UNITS);

  bba_pkg::state_e state_q, state_d;

  logic [1:0]    req_q, req_d;
  logic [15:0]   size_q, size_d;
  logic [15:0]   addr_q, addr_d;
  logic [LI-1:0] lvl_q, lvl_d;
  logic [LI-1:0] tgt_q, tgt_d;
  logic [BW-1:0] blk_q, blk_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q [SPAN+1];
  logic [CW-1:0] cnt_d [SPAN+1];
  logic [TW-1:0] tbu_q, tbu_d;
  logic [TW-1:0] init_n_q, init_n_d;
  logic          resp_q, resp_d;
  logic [1:0]    sts_q, sts_d;
  logic [15:0]   gaddr_q, gaddr_d;
  logic [3:0]    gord_q, gord_d;
  logic          ov_q, ov_d;
  logic [1:0]    ost_q, ost_d;
  logic [15:0]   oaddr_q, oaddr_d;
  logic [3:0]    oord_q, oord_d;

  logic          sm_we;
  logic [AW-1:0] sm_waddr, sm_raddr;
  logic [BW-1:0] sm_wdata, sm_rdata;
  logic          rec_we;
  logic [BW-1:0] rec_waddr, rec_raddr;
  logic [OW-1:0] rec_wdata, rec_rdata;

  // Shared decode of the level being worked on
  logic [LI-1:0] cur_lvl;
  logic [CW-1:0] cur_cnt;
  logic [CW-1:0] cur_cap;
  logic [AW-1:0] cur_base;
  logic [BW-1:0] bud;
  logic          scan_hit;
  logic          more_up;
  logic [16:0]   need;
  logic          fit;
  logic [LI-1:0] kk;
  logic [15:0]   off;
  logic [15:0]   blkw;
  logic          blk_ok;
  logic [OW-1:0] kr;
  logic [LI-1:0] klvl;
  logic          init_more;

  assign cur_lvl  = (state_q == bba_pkg::S_SPLIT) ? lvl_q - LI'(1) : lvl_q;
  assign cur_cnt  = cnt_q[cur_lvl];
  assign cur_cap  = CW'(UNITS >> cur_lvl);
  assign cur_base = AW'(TWO_U - (TWO_U >> cur_lvl));
  assign bud      = blk_q ^ (BW'(1) << lvl_q);
  assign scan_hit = (sm_rdata == bud);
  assign more_up  = (32'(idx_q) + 32'd1) < 32'(cur_cnt);
  assign init_more = 32'(idx_q) < 32'(init_n_q);

  // Smallest order that holds the request plus header
  always_comb begin
    need = 17'(size_q) + 17'(bba_pkg::HDR_BYTES);
    fit  = 1'b0;
    kk   = '0;
    for (int o = ORD_MAX; o >= ORD_MIN; o--) begin
      if (32'(need) <= (32'd1 << o)) begin
        fit = 1'b1;
        kk  = LI'(o - ORD_MIN);
      end
    end
  end

  // Free address decode and recorded order clamp
  always_comb begin
    off    = addr_q - 16'(bba_pkg::HDR_BYTES);
    blkw   = off >> ORD_MIN;
    blk_ok = 32'(blkw) < UNITS;
    kr     = rec_rdata;
    if (32'(kr) < ORD_MIN) begin
      kr = OW'(ORD_MIN);
    end
    if (32'(kr) > ORD_MAX) begin
      kr = OW'(ORD_MAX);
    end
    klvl = LI'(kr - OW'(ORD_MIN));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::S_INIT: begin
        if (!init_more) begin
          state_d = resp_q ? bba_pkg::S_DONE : bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        case (req_q)
          bba_pkg::REQ_ALLOC:
            state_d = (size_q != '0 && fit) ? bba_pkg::S_SEARCH : bba_pkg::S_DONE;
          bba_pkg::REQ_FREE:
            state_d = (addr_q != '0 && blk_ok) ? bba_pkg::S_REC : bba_pkg::S_DONE;
          bba_pkg::REQ_INIT:
            state_d = bba_pkg::S_INIT;
          default:
            state_d = bba_pkg::S_DONE;
        endcase
      end
      bba_pkg::S_SEARCH: begin
        if (cur_cnt != '0) begin
          state_d = bba_pkg::S_POP;
        end else if (32'(lvl_q) == SPAN) begin
          state_d = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_POP:   state_d = bba_pkg::S_SPLIT;
      bba_pkg::S_SPLIT: begin
        if (lvl_q == tgt_q) begin
          state_d = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_REC:   state_d = bba_pkg::S_MCHK;
      bba_pkg::S_MCHK: begin
        state_d = (32'(lvl_q) == SPAN || cur_cnt == '0) ? bba_pkg::S_PUSH : bba_pkg::S_SCAN;
      end
      bba_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = more_up ? bba_pkg::S_SHIFT : bba_pkg::S_MCHK;
        end else if (idx_q == '0) begin
          state_d = bba_pkg::S_PUSH;
        end
      end
      bba_pkg::S_SHIFT: begin
        if (!more_up) begin
          state_d = bba_pkg::S_MCHK;
        end
      end
      bba_pkg::S_PUSH:  state_d = bba_pkg::S_DONE;
      bba_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      default:          state_d = bba_pkg::S_IDLE;
    endcase
  end

  // Memory port drive
  always_comb begin
    sm_we     = 1'b0;
    sm_waddr  = cur_base + AW'(cur_cnt);
    sm_wdata  = blk_q;
    sm_raddr  = cur_base + AW'(cur_cnt) - AW'(1);
    rec_we    = 1'b0;
    rec_waddr = blk_q;
    rec_wdata = OW'(tgt_q) + OW'(ORD_MIN);
    rec_raddr = BW'(blkw);
    unique case (state_q)
      bba_pkg::S_INIT: begin
        sm_we    = init_more;
        sm_waddr = cur_base + AW'(idx_q);
        sm_wdata = BW'(idx_q) << SPAN;
      end
      bba_pkg::S_SPLIT: begin
        if (lvl_q == tgt_q) begin
          rec_we = 1'b1;
        end else begin
          sm_we    = cur_cnt < cur_cap;
          sm_wdata = blk_q + (BW'(1) << cur_lvl);
        end
      end
      bba_pkg::S_SCAN: begin
        sm_raddr = scan_hit ? cur_base + AW'(idx_q) + AW'(1)
                            : cur_base + AW'(idx_q) - AW'(1);
      end
      bba_pkg::S_SHIFT: begin
        sm_we    = 1'b1;
        sm_waddr = cur_base + AW'(idx_q) - AW'(1);
        sm_wdata = sm_rdata;
        sm_raddr = cur_base + AW'(idx_q) + AW'(1);
      end
      bba_pkg::S_PUSH: begin
        sm_we = cur_cnt < cur_cap;
      end
      default: begin
      end
    endcase
  end

  // Datapath and counts
  always_comb begin
    req_d    = req_q;
    size_d   = size_q;
    addr_d   = addr_q;
    lvl_d    = lvl_q;
    tgt_d    = tgt_q;
    blk_d    = blk_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    init_n_d = init_n_q;
    resp_d   = resp_q;
    sts_d    = sts_q;
    gaddr_d  = gaddr_q;
    gord_d   = gord_q;
    ov_d     = ov_q && !out_ready_i;
    ost_d    = ost_q;
    oaddr_d  = oaddr_q;
    oord_d   = oord_q;
    tbu_d    = tbu_q;

    // Load the config register, saturated to 1..TOP_BLOCKS
    if (cfg_we_i) begin
      tbu_d = TW'(cfg_wdata_i);
      if (cfg_wdata_i == '0) begin
        tbu_d = TW'(1);
      end
      if (32'(cfg_wdata_i) > TOP_BLOCKS) begin
        tbu_d = TW'(TOP_BLOCKS);
      end
    end

    case (state_q)
      bba_pkg::S_INIT: begin
        if (init_more) begin
          idx_d       = idx_q + CW'(1);
          cnt_d[SPAN] = idx_q + CW'(1);
        end
      end
      bba_pkg::S_IDLE: begin
        req_d   = req_type_i;
        size_d  = request_size_i;
        addr_d  = address_i;
        sts_d   = bba_pkg::STS_IGNORED;
        gaddr_d = '0;
        gord_d  = '0;
      end
      bba_pkg::S_DECODE: begin
        case (req_q)
          bba_pkg::REQ_ALLOC: begin
            if (size_q != '0) begin
              if (fit) begin
                tgt_d = kk;
                lvl_d = kk;
              end else begin
                sts_d = bba_pkg::STS_TOO_BIG;
              end
            end
          end
          bba_pkg::REQ_FREE: begin
            blk_d = BW'(blkw);
          end
          bba_pkg::REQ_INIT: begin
            for (int l = 0; l <= SPAN; l++) begin
              cnt_d[l] = '0;
            end
            lvl_d    = LI'(SPAN);
            idx_d    = '0;
            init_n_d = tbu_q;
            resp_d   = 1'b1;
            sts_d    = bba_pkg::STS_OK;
          end
          default: begin
          end
        endcase
      end
      bba_pkg::S_SEARCH: begin
        if (cur_cnt != '0) begin
          cnt_d[cur_lvl] = cur_cnt - CW'(1);
        end else if (32'(lvl_q) == SPAN) begin
          sts_d = bba_pkg::STS_NO_MEM;
        end else begin
          lvl_d = lvl_q + LI'(1);
        end
      end
      bba_pkg::S_POP: begin
        blk_d = sm_rdata;
      end
      bba_pkg::S_SPLIT: begin
        if (lvl_q == tgt_q) begin
          sts_d   = bba_pkg::STS_OK;
          gaddr_d = 16'((32'(blk_q) << ORD_MIN) + bba_pkg::HDR_BYTES);
          gord_d  = 4'(32'(tgt_q) + ORD_MIN);
        end else begin
          lvl_d = cur_lvl;
          if (cur_cnt < cur_cap) begin
            cnt_d[cur_lvl] = cur_cnt + CW'(1);
          end
        end
      end
      bba_pkg::S_REC: begin
        lvl_d = klvl;
        blk_d = blk_q & ({BW{1'b1}} << klvl);
      end
      bba_pkg::S_MCHK: begin
        idx_d = cur_cnt - CW'(1);
      end
      bba_pkg::S_SCAN: begin
        if (scan_hit) begin
          if (more_up) begin
            idx_d = idx_q + CW'(1);
          end else begin
            cnt_d[cur_lvl] = cur_cnt - CW'(1);
            blk_d          = blk_q & ~(BW'(1) << lvl_q);
            lvl_d          = lvl_q + LI'(1);
          end
        end else if (idx_q != '0) begin
          idx_d = idx_q - CW'(1);
        end
      end
      bba_pkg::S_SHIFT: begin
        if (more_up) begin
          idx_d = idx_q + CW'(1);
        end else begin
          cnt_d[cur_lvl] = cur_cnt - CW'(1);
          blk_d          = blk_q & ~(BW'(1) << lvl_q);
          lvl_d          = lvl_q + LI'(1);
        end
      end
      bba_pkg::S_PUSH: begin
        sts_d = bba_pkg::STS_OK;
        if (cur_cnt < cur_cap) begin
          cnt_d[cur_lvl] = cur_cnt + CW'(1);
        end
      end
      bba_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ost_d   = sts_q;
          oaddr_d = gaddr_q;
          oord_d  = gord_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bba_pkg::S_INIT;
      lvl_q    <= LI'(SPAN);
      idx_q    <= '0;
      init_n_q <= TW'(TBU_RST);
      tbu_q    <= TW'(TBU_RST);
      resp_q   <= 1'b0;
      ov_q     <= 1'b0;
      for (int l = 0; l <= SPAN; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q  <= state_d;
      lvl_q    <= lvl_d;
      idx_q    <= idx_d;
      init_n_q <= init_n_d;
      tbu_q    <= tbu_d;
      resp_q   <= resp_d;
      ov_q     <= ov_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    size_q  <= size_d;
    addr_q  <= addr_d;
    tgt_q   <= tgt_d;
    blk_q   <= blk_d;
    sts_q   <= sts_d;
    gaddr_q <= gaddr_d;
    gord_q  <= gord_d;
    ost_q   <= ost_d;
    oaddr_q <= oaddr_d;
    oord_q  <= oord_d;
  end

  bba_ram #(
    .DEPTH (2 * UNITS),
    .WIDTH (BW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  bba_ram #(
    .DEPTH (UNITS),
    .WIDTH (OW)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  assign in_ready_o        = (state_q == bba_pkg::S_IDLE);
  assign out_valid_o       = ov_q;
  assign status_o          = ost_q;
  assign granted_address_o = oaddr_q;
  assign granted_order_o   = oord_q;

endmodule

`default_nettype wire

>>> hdl/bba_checker.sv
`default_nettype none

module bba_checker #(
  parameter int unsigned ORD_MIN = 4
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] granted_address_o,
  input wire logic [3:0]  granted_order_o
);

  // Hold a stalled result transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_address_o) && $stable(granted_order_o))
    else $error("result changed while stalled");

  // Drop grant fields on every failure
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bba_pkg::STS_OK
      |-> granted_address_o == '0 && granted_order_o == '0)
    else $error("grant fields set on a failed request");

  // Granted address is an aligned block plus the header
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_order_o != '0 |-> granted_address_o[1:0] == 2'b10)
    else $error("granted address misaligned");

  // Granted order never below the smallest block
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_order_o != '0 |-> 32'(granted_order_o) >= ORD_MIN)
    else $error("granted order below minimum");

endmodule

bind buddy_block_allocator bba_checker #(
  .ORD_MIN (ORD_MIN)
) u_bba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .granted_address_o (granted_address_o),
  .granted_order_o   (granted_order_o)
);

`default_nettype wire

>>> sim/tb_buddy_block_allocator.sv
`default_nettype none

module tb_buddy_block_allocator;

  localparam int unsigned MIN_ORD   = 4;
  localparam int unsigned MAX_ORD   = 12;
  localparam int unsigned TOP_BLK   = 16;
  localparam int unsigned SPAN      = MAX_ORD - MIN_ORD;
  localparam int unsigned UNITS     = TOP_BLK << SPAN;
  localparam int unsigned N_ITEMS   = 1350;
  localparam int unsigned N_PHASES  = 6;

  typedef struct packed {
    bba_pkg::status_e status;
    logic [15:0]      gaddr;
    logic [3:0]       gorder;
  } grant_t;

  // Free-list model of the arena and the queue of grants still to be answered
  class alloc_scoreboard;
    int unsigned free_blk[SPAN+1][UNITS];
    int unsigned free_cnt[SPAN+1];
    logic [3:0]  order_rec[UNITS];
    int unsigned top_in_use;
    grant_t      pending[$];
    int unsigned errors;

    function void push_blk(int unsigned lvl, int unsigned blk);
      if (free_cnt[lvl] < (UNITS >> lvl)) begin
        free_blk[lvl][free_cnt[lvl]] = blk;
        free_cnt[lvl]++;
      end
    endfunction

    // Remove the topmost copy of blk, keeping the order of the rest
    function bit take_blk(int unsigned lvl, int unsigned blk);
      int i;
      for (i = int'(free_cnt[lvl]) - 1; i >= 0; i--) begin
        if (free_blk[lvl][i] == blk) begin
          for (int j = i; j < int'(free_cnt[lvl]) - 1; j++)
            free_blk[lvl][j] = free_blk[lvl][j+1];
          free_cnt[lvl]--;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void refill();
      for (int l = 0; l <= SPAN; l++) free_cnt[l] = 0;
      for (int unsigned i = 0; i < top_in_use; i++) push_blk(SPAN, i << SPAN);
    endfunction

    function void set_top(logic [4:0] v);
      top_in_use = (v < 1) ? 1 : (v > TOP_BLK) ? TOP_BLK : 32'(v);
    endfunction

    function new();
      top_in_use = (TOP_BLK < 16) ? TOP_BLK : 16;
      errors = 0;
      refill();
    endfunction

    // Note an accepted request; returns the grant it must produce
    function grant_t note(logic [1:0] rt, logic [15:0] sz, logic [15:0] ad);
      grant_t      g;
      int unsigned k, cur, blk, bud, off;
      g = '{bba_pkg::STS_IGNORED, 16'd0, 4'd0};
      if (rt == bba_pkg::REQ_ALLOC && sz != 0) begin
        k = MIN_ORD;
        while (k <= MAX_ORD && (32'd1 << k) < 32'(sz) + bba_pkg::HDR_BYTES) k++;
        if (k > MAX_ORD) g.status = bba_pkg::STS_TOO_BIG;
        else begin
          cur = k;
          while (cur <= MAX_ORD && free_cnt[cur-MIN_ORD] == 0) cur++;
          if (cur > MAX_ORD) g.status = bba_pkg::STS_NO_MEM;
          else begin
            free_cnt[cur-MIN_ORD]--;
            blk = free_blk[cur-MIN_ORD][free_cnt[cur-MIN_ORD]];
            while (cur > k) begin
              cur--;
              push_blk(cur - MIN_ORD, blk + (1 << (cur - MIN_ORD)));
            end
            if (blk < UNITS) order_rec[blk] = 4'(k);
            g.status = bba_pkg::STS_OK;
            g.gaddr  = 16'((blk << MIN_ORD) + bba_pkg::HDR_BYTES);
            g.gorder = 4'(k);
          end
        end
      end else if (rt == bba_pkg::REQ_FREE && ad != 0) begin
        off = (32'(ad) - bba_pkg::HDR_BYTES) & 32'hFFFF;
        blk = off >> MIN_ORD;
        if (blk < UNITS) begin
          k = 32'(order_rec[blk]);
          if (k < MIN_ORD) k = MIN_ORD;
          if (k > MAX_ORD) k = MAX_ORD;
          blk &= ~((1 << (k - MIN_ORD)) - 1);
          while (k < MAX_ORD) begin
            bud = blk ^ (1 << (k - MIN_ORD));
            if (!take_blk(k - MIN_ORD, bud)) break;
            if (bud < blk) blk = bud;
            k++;
          end
          push_blk(k - MIN_ORD, blk);
          g.status = bba_pkg::STS_OK;
        end
      end else if (rt == bba_pkg::REQ_INIT) begin
        refill();
        g.status = bba_pkg::STS_OK;
      end
      pending.push_back(g);
      return g;
    endfunction

    function void check(logic [1:0] st, logic [15:0] ga, logic [3:0] go);
      grant_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: st=%0d ga=%h go=%0d", st, ga, go);
        return;
      end
      w = pending.pop_front();
      if (st !== w.status || ga !== w.gaddr || go !== w.gorder) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d ga=%h go=%0d, got st=%0d ga=%h go=%0d",
                   w.status, w.gaddr, w.gorder, st, ga, go);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [15:0] request_size_i = '0;
  logic [15:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] granted_address_o;
  logic [3:0]  granted_order_o;

  alloc_scoreboard sb = new();
  bit          calm;           // no idling on either side while set
  logic [15:0] live_addr[$];   // granted and not yet freed
  logic [15:0] old_addr[$];    // once granted, record written
  int unsigned sent;

  buddy_block_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .req_type_i, .request_size_i, .address_i,
    .out_valid_o, .out_ready_i, .status_o, .granted_address_o, .granted_order_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(status_o, granted_address_o, granted_order_o);
    out_ready_i <= calm || ($urandom_range(99) >= 35);
  end

  task automatic send(logic [1:0] rt, logic [15:0] sz, logic [15:0] ad);
    grant_t g;
    int     gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rt;
    request_size_i <= sz;
    address_i      <= ad;
    do @(posedge clk_i); while (!in_ready_o);
    g = sb.note(rt, sz, ad);
    sent++;
    if (rt == bba_pkg::REQ_ALLOC && g.status == bba_pkg::STS_OK) begin
      live_addr.push_back(g.gaddr);
      old_addr.push_back(g.gaddr);
    end
    if (rt == bba_pkg::REQ_INIT) live_addr.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_top(logic [4:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_top(v);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 16'($urandom_range(1, 60));
    if (r < 85) return 16'($urandom_range(61, 1000));
    if (r < 93) return 16'($urandom_range(1001, 4094));
    if (r < 98) return 16'($urandom_range(4095, 65535));
    return 16'd0;
  endfunction

  // Free request: mostly well-formed, some misaligned, double or null
  function automatic logic [15:0] pick_free();
    int          r, i;
    logic [15:0] a;
    r = $urandom_range(99);
    if (r < 75 && live_addr.size() != 0) begin
      i = $urandom_range(live_addr.size() - 1);
      a = live_addr[i];
      live_addr.delete(i);
      return a;
    end
    if (r < 97 && old_addr.size() != 0) begin
      a = old_addr[$urandom_range(old_addr.size() - 1)];
      if (r >= 85) a = a + 16'($urandom_range(13));
      return a;
    end
    return 16'd0;
  endfunction

  initial begin
    logic [4:0] tops[N_PHASES];
    int         r;
    tops = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'($urandom_range(31))};
    calm = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every request, special cases
    send(bba_pkg::REQ_ALLOC, 16'd0, 16'hFFFF);
    send(bba_pkg::REQ_ALLOC, 16'hFFFF, 16'h0000);
    send(bba_pkg::REQ_ALLOC, 16'd4095, 16'd0);
    send(bba_pkg::REQ_ALLOC, 16'd4094, 16'd0);
    send(bba_pkg::REQ_ALLOC, 16'd1, 16'd0);
    send(bba_pkg::REQ_ALLOC, 16'd14, 16'd0);
    send(bba_pkg::REQ_ALLOC, 16'd15, 16'd0);
    send(bba_pkg::REQ_FREE, 16'hFFFF, 16'd0);
    send(bba_pkg::REQ_RSVD, 16'hFFFF, 16'hFFFF);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[2] + 16'd5);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[3]);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[1]);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[0]);
    live_addr.delete();
    for (int i = 0; i < 17; i++) send(bba_pkg::REQ_ALLOC, 16'd4000, 16'd0);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[old_addr.size()-1]);
    send(bba_pkg::REQ_FREE, 16'd0, old_addr[old_addr.size()-1]);
    send(bba_pkg::REQ_INIT, 16'd0, 16'd0);
    drain();

    // Random phases, each under its own arena size
    for (int p = 0; p < N_PHASES; p++) begin
      write_top(tops[p]);
      send(bba_pkg::REQ_INIT, 16'($urandom), 16'($urandom));
      for (int n = 0; n < N_ITEMS / N_PHASES; n++) begin
        calm = (p == 2 && n >= 40 && n < 160);
        r = $urandom_range(99);
        if (r < 50) send(bba_pkg::REQ_ALLOC, pick_size(), 16'($urandom));
        else if (r < 94) send(bba_pkg::REQ_FREE, 16'($urandom), pick_free());
        else if (r < 97) send(bba_pkg::REQ_INIT, 16'($urandom), 16'($urandom));
        else send(bba_pkg::REQ_RSVD, 16'($urandom), 16'($urandom));
      end
      calm = 1'b0;
      drain();
    end

    if (sb.errors == 0) $display("tb_buddy_block_allocator OK");
    else $display("tb_buddy_block_allocator NOT OK");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("tb_buddy_block_allocator NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
